@@ rtl/core/ws2811_spi_bit_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// WS2811 SPI bit encoder assertion macros
// Concurrent assertion helpers used by the encoder back.
// ----------------------------------------------------------------------------
`ifndef WS2811_SPI_BIT_ENCODER_MACROS_SVH
`define WS2811_SPI_BIT_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define WSBE_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WSBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WSBE_ASSERT(label, clk, rst_n, ante, cons, msg)
`define WSBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/wsbe_pkg.sv @@
// ----------------------------------------------------------------------------
// WS2811 SPI bit encoder package
// Shared constants, types and the nibble-to-symbol encoding function.
// ----------------------------------------------------------------------------
`default_nettype none

package wsbe_pkg;

  // Byte queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Field and register widths.
  localparam int unsigned WordW   = 16;
  localparam int unsigned CountW  = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgInvert = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLatch  = 2'd1;

  // Line symbols and levels.
  localparam logic [3:0]        SymOne     = 4'hC;
  localparam logic [3:0]        SymZero    = 4'h8;
  localparam logic [WordW-1:0]  LowLevel   = 16'h0000;
  localparam logic [CountW-1:0] LatchReset = 6'd11;
  localparam logic [CountW-1:0] LatchMin   = 6'd1;
  localparam logic [CountW-1:0] LatchMax   = 6'd62;

  // One queued byte, already encoded into its two words.
  typedef struct packed {
    logic [WordW-1:0] hi_word;
    logic [WordW-1:0] lo_word;
    logic             last;
  } entry_t;

  // Live configuration.
  typedef struct packed {
    logic              invert;
    logic [CountW-1:0] latch_words;
  } cfg_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Expand a nibble into four symbols, MSB first.
  function automatic logic [WordW-1:0] encode_nibble(input logic [3:0] nib);
    logic [WordW-1:0] word;
    word = '0;
    for (int b = 0; b < 4; b++) begin
      word[WordW-1-4*b -: 4] = nib[3-b] ? SymOne : SymZero;
    end
    return word;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ws2811_spi_bit_encoder.sv @@
// Path: a pushed byte is encoded into the queue, then its high word is loaded into the
// output register. Throughput: one output word per cycle while the receiver pops or the
// register is empty; two words per byte, plus the latch run after a byte marked last.
// Reset: synchronous, active low; clears the queue count, the sequencer and the output valid bit,
// and sets invert to 0 and latch_words to 11. No clearing pass is needed.
// ----------------------------------------------------------------------------
// WS2811 SPI bit encoder
// Turns LED color bytes into 4-bit-per-bit SPI words with a latch run per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ws2811_spi_bit_encoder
  import wsbe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic [WordW-1:0]        out_spi_word,
  output logic                    out_end_of_frame,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgDatW-1:0] cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  head_t head;
  logic  deq;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CfgInvert: cfg_nxt.invert      = cfg_wdata[0];
        CfgLatch:  cfg_nxt.latch_words = cfg_wdata[CountW-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert      <= 1'b0;
      cfg_r.latch_words <= LatchReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accepts and encodes bytes into the queue.
  wsbe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .head         (head),
    .deq          (deq)
  );

  // Back: emits data and latch words.
  wsbe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (head),
    .deq              (deq),
    .empty            (empty),
    .pop              (pop),
    .out_spi_word     (out_spi_word),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

`default_nettype wire

@@ rtl/core/wsbe_front.sv @@
// ----------------------------------------------------------------------------
// WS2811 SPI bit encoder front
// Accepts color bytes, encodes both nibbles and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsbe_front
  import wsbe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output head_t           head,
  input  wire logic       deq
);

  entry_t            entry_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              push_ok;
  entry_t            new_entry;

  // Encode the incoming byte on the way into the queue.
  always_comb begin
    new_entry.hi_word = encode_nibble(in_data_byte[7:4]);
    new_entry.lo_word = encode_nibble(in_data_byte[3:0]);
    new_entry.last    = in_last_byte;
  end

  assign full    = (cnt_r == QCntW'(QDepth));
  assign push_ok = push && !full;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    unique case ({push_ok, deq})
      2'b10:   cnt_nxt = cnt_r + QCntW'(1);
      2'b01:   cnt_nxt = cnt_r - QCntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.entry = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

@@ rtl/core/wsbe_back.sv @@
// ----------------------------------------------------------------------------
// WS2811 SPI bit encoder back
// Sequences data words and latch words into a one-word output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ws2811_spi_bit_encoder_macros.svh"

module wsbe_back
  import wsbe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire head_t        head,
  output logic              deq,
  output logic              empty,
  input  wire logic         pop,
  output logic [WordW-1:0]  out_spi_word,
  output logic              out_end_of_frame
);

  typedef enum logic [1:0] {
    PH_HI,
    PH_LO,
    PH_LATCH
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic              valid_r, valid_nxt;
  logic [WordW-1:0]  word_r, word_nxt;
  logic              eof_r, eof_nxt;
  logic              out_free;
  logic [WordW-1:0]  inv_mask;
  logic [CountW-1:0] latch_cnt;

  // The output register can load when it is empty or being drained.
  assign out_free = !valid_r || pop;
  assign inv_mask = {WordW{cfg.invert}};

  // Clamp the latch run to its legal range.
  always_comb begin
    priority if (cfg.latch_words < LatchMin) begin
      latch_cnt = LatchMin;
    end else if (cfg.latch_words > LatchMax) begin
      latch_cnt = LatchMax;
    end else begin
      latch_cnt = cfg.latch_words;
    end
  end

  // Word sequencer.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r && !pop;
    word_nxt  = word_r;
    eof_nxt   = eof_r;
    deq       = 1'b0;
    if (out_free) begin
      unique case (phase_r)
        PH_HI: begin
          if (head.valid) begin
            valid_nxt = 1'b1;
            word_nxt  = head.entry.hi_word ^ inv_mask;
            eof_nxt   = 1'b0;
            phase_nxt = PH_LO;
          end
        end
        PH_LO: begin
          valid_nxt = 1'b1;
          word_nxt  = head.entry.lo_word ^ inv_mask;
          eof_nxt   = 1'b0;
          deq       = 1'b1;
          if (head.entry.last) begin
            phase_nxt = PH_LATCH;
            cnt_nxt   = latch_cnt;
          end else begin
            phase_nxt = PH_HI;
          end
        end
        PH_LATCH: begin
          valid_nxt = 1'b1;
          word_nxt  = LowLevel ^ inv_mask;
          eof_nxt   = (cnt_r == CountW'(1));
          cnt_nxt   = cnt_r - CountW'(1);
          if (cnt_r == CountW'(1)) begin
            phase_nxt = PH_HI;
          end
        end
        default: begin
          phase_nxt = PH_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HI;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
    eof_r  <= eof_nxt;
  end

  assign empty            = !valid_r;
  assign out_spi_word     = word_r;
  assign out_end_of_frame = eof_r;

  // A flagged word is always the latch level.
  `WSBE_ASSERT(a_eof_is_low, clk, rst_n, valid_r && eof_r, word_r == (LowLevel ^ inv_mask), "end-of-frame word is not the latch level")
  // The latch run never sits at a zero count.
  `WSBE_ASSERT(a_latch_cnt, clk, rst_n, phase_r == PH_LATCH, cnt_r != '0, "latch phase with zero count")
  // A byte leaves the queue only when one is there.
  `WSBE_ASSERT(a_deq_valid, clk, rst_n, deq, head.valid, "dequeue from an empty queue")
  // After the low word of a plain byte the sequencer returns to the high word.
  `WSBE_ASSERT_NEXT(a_lo_next, clk, rst_n, deq && !head.entry.last, phase_r == PH_HI, "sequencer did not return to the high word")

endmodule

`default_nettype wire

@@ tb/sv/ws2811_spi_bit_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2811 SPI bit encoder testbench
// Pushes color bytes, grouped into frames, through the encoder under several
// invert and latch-length settings. The expected SPI words are computed
// independently and every popped word is compared against them. Both queue
// sides idle at random. One long output hold fills the encoder and stalls
// its input.
// ----------------------------------------------------------------------------

module ws2811_spi_bit_encoder_tb;
  import wsbe_pkg::*;

  // Register indexes that decode to no register.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam int CycleLimit = 600000;
  localparam int LongHold   = 300;

  // One expected output word.
  typedef struct {
    logic [WordW-1:0] word;
    logic             eof;
  } spi_result_t;

  // Encodes accepted bytes into the words they must produce and checks popped words.
  class spi_word_scoreboard;
    logic              invert;
    logic [CountW-1:0] latch_len;
    spi_result_t       expected_words[$];
    int                errors;
    int                words_checked;
    int                bytes_seen;
    int                frames_seen;

    function new();
      invert        = 1'b0;
      latch_len     = LatchReset;
      errors        = 0;
      words_checked = 0;
      bytes_seen    = 0;
      frames_seen   = 0;
    endfunction

    // Register writes to an unused index leave the settings alone.
    function void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
      case (idx)
        CfgInvert: invert = val[0];
        CfgLatch:  latch_len = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    // Four line symbols per nibble, most significant bit first, then the output polarity.
    function logic [WordW-1:0] line_word(logic [3:0] nib);
      logic [WordW-1:0] w;
      w = '0;
      for (int b = 3; b >= 0; b--) begin
        w = {w[WordW-5:0], (nib[b] ? SymOne : SymZero)};
      end
      return invert ? ~w : w;
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      logic [CountW-1:0] run;
      logic [WordW-1:0]  low;
      expected_words.push_back('{line_word(data[7:4]), 1'b0});
      expected_words.push_back('{line_word(data[3:0]), 1'b0});
      bytes_seen++;
      if (last) begin
        // The latch run is clamped to 1..62; only its final word flags end of frame.
        run = latch_len;
        if (run < LatchMin) run = LatchMin;
        if (run > LatchMax) run = LatchMax;
        low = invert ? ~LowLevel : LowLevel;
        for (int i = 0; i < run; i++) begin
          expected_words.push_back('{low, (i == run - 1)});
        end
        frames_seen++;
      end
    endfunction

    function void check_word(logic [WordW-1:0] word, logic eof);
      spi_result_t exp_res;
      if (expected_words.size() == 0) begin
        $error("Unexpected SPI word %h (end_of_frame %b) with nothing outstanding", word, eof);
        errors++;
        return;
      end
      exp_res = expected_words.pop_front();
      words_checked++;
      if (word !== exp_res.word) begin
        $error("spi_word mismatch: expected %h, got %h", exp_res.word, word);
        errors++;
      end
      if (eof !== exp_res.eof) begin
        $error("end_of_frame mismatch: expected %b, got %b", exp_res.eof, eof);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [WordW-1:0]   out_spi_word;
  logic               out_end_of_frame;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_wdata = '0;

  spi_word_scoreboard sb = new();

  int tx_gap_max   = 0;
  int rx_stall_max = 0;
  int hold_request = 0;
  int longest_hold = 0;
  int full_stalls  = 0;
  int reg_writes   = 0;

  ws2811_spi_bit_encoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .empty            (empty),
    .pop              (pop),
    .out_spi_word     (out_spi_word),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit well beyond the slowest legal run.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles with %0d words outstanding", CycleLimit, sb.pending());
    $display("simulation failed");
    $finish;
  end

  // Offer one byte after a random gap; push stays high after the transfer.
  task automatic send_byte(input logic [7:0] data, input logic last);
    int   gap;
    logic blocked;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do begin
      @(posedge clk);
      blocked = full;
      if (blocked) full_stalls++;
    end while (blocked);
    sb.note_byte(data, last);
  endtask

  // Drop push and wait until every expected word has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.apply_write(idx, val);
    reg_writes++;
  endtask

  // Random frames of 1..8 bytes; the phase always closes its last frame.
  task automatic run_phase(input int n_bytes, input int pause_at);
    int   frame_left;
    logic last;
    frame_left = $urandom_range(1, 8);
    for (int i = 0; i < n_bytes; i++) begin
      if (i == pause_at) begin
        push <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      last = (frame_left == 1) || (i == n_bytes - 1);
      send_byte(8'($urandom_range(0, 255)), last);
      frame_left--;
      if (frame_left == 0) frame_left = $urandom_range(1, 8);
    end
  endtask

  // Receiver: random stalls per word, plus a long hold on request.
  initial begin
    int wait_cycles;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        wait_cycles  = hold_request;
        hold_request = 0;
        if (wait_cycles > longest_hold) longest_hold = wait_cycles;
      end else begin
        wait_cycles = $urandom_range(0, rx_stall_max);
      end
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_word(out_spi_word, out_end_of_frame);
    end
  end

  // Main sequence.
  initial begin
    logic [CfgDatW-1:0] latch_pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: plain polarity, eleven latch words, back-to-back frames.
    tx_gap_max   = 3;
    rx_stall_max = 3;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b1);
    wait_drained();

    // Inverted output with the shortest latch run.
    write_reg(CfgInvert, 6'h01);
    write_reg(CfgLatch, 6'd1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    wait_drained();

    // A zero latch count still ends the frame with one flagged word;
    // only bit 0 of the invert write counts.
    write_reg(CfgLatch, 6'd0);
    write_reg(CfgInvert, 6'h3E);
    send_byte(8'h81, 1'b1);
    wait_drained();

    // A count of 63 saturates to 62.
    write_reg(CfgLatch, 6'd63);
    write_reg(CfgInvert, 6'h3F);
    send_byte(8'h7E, 1'b1);
    wait_drained();

    // Writes to unused indexes must leave both registers alone.
    write_reg(CfgLatch, LatchMax);
    write_reg(CfgInvert, 6'h00);
    write_reg(CfgSpareA, 6'h3F);
    write_reg(CfgSpareB, 6'h01);
    send_byte(8'h96, 1'b1);
    wait_drained();

    // Random phases, each under fresh settings and its own idling pattern.
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 7))
        0:       latch_pick = 6'd0;
        1:       latch_pick = 6'd63;
        2:       latch_pick = LatchMax;
        default: latch_pick = 6'($urandom_range(1, 12));
      endcase
      write_reg(CfgInvert, 6'($urandom_range(0, 63)));
      write_reg(CfgLatch, latch_pick);
      if ($urandom_range(0, 1)) begin
        write_reg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, 6'($urandom_range(0, 63)));
      end
      case (phase)
        0: begin
          tx_gap_max   = 0;
          rx_stall_max = 0;
          run_phase(16, -1);
        end
        1: begin
          tx_gap_max   = 6;
          rx_stall_max = 6;
          run_phase(16, -1);
        end
        2: begin
          // Hold the output long enough for the encoder to fill and refuse input.
          tx_gap_max   = 0;
          rx_stall_max = 2;
          hold_request = LongHold;
          run_phase(20, -1);
        end
        3: begin
          // The sender pauses halfway until everything has come out.
          tx_gap_max   = 6;
          rx_stall_max = 0;
          run_phase(16, 8);
        end
        4: begin
          tx_gap_max   = 0;
          rx_stall_max = 6;
          run_phase(16, -1);
        end
        default: begin
          tx_gap_max   = 3;
          rx_stall_max = 3;
          run_phase(16, -1);
        end
      endcase
      wait_drained();
    end

    // Let any stray words surface before the verdict.
    repeat (20) @(posedge clk);
    $display("Encoded %0d bytes in %0d frames; %0d SPI words checked after %0d register writes.",
             sb.bytes_seen, sb.frames_seen, sb.words_checked, reg_writes);
    $display("Input refused for %0d cycles; longest output hold %0d cycles.",
             full_stalls, longest_hold);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d words never seen", sb.errors, sb.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/wsbe_pkg.sv
rtl/core/wsbe_front.sv
rtl/core/wsbe_back.sv
rtl/core/ws2811_spi_bit_encoder.sv
tb/sv/ws2811_spi_bit_encoder_tb.sv
